// ===== rtl/core/osd_pkg.sv =====
// Shared types and constants of the odometry slip detector.
package osd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLIP_THRESHOLD   = 8'd0,
        CFG_SLIP_COUNT_LIMIT = 8'd1,
        CFG_CAUGHT_HOLD_TIME = 8'd2,
        CFG_AVERAGE_WEIGHT   = 8'd3
    } cfg_index_t;

    // Register values after reset.
    localparam logic [30:0] SLIP_THRESHOLD_RST   = 31'd6554;
    localparam logic [14:0] SLIP_COUNT_LIMIT_RST = 15'd5;
    localparam logic [15:0] CAUGHT_HOLD_TIME_RST = 16'd30;
    localparam logic [15:0] AVERAGE_WEIGHT_RST   = 16'd19661;

    // Average weight is Q0.16; this is one half in that scale, used for rounding.
    localparam int AVG_SHIFT = 16;
    localparam logic signed [49:0] AVG_ROUND = 50'sd32768;

    // Slip run and hold counter limits.
    localparam logic signed [15:0] RUN_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] RUN_MIN  = 16'sh8000;
    localparam logic [15:0]        HOLD_MAX = 16'hFFFF;

    typedef struct packed {
        logic signed [31:0] walk_forward;
        logic signed [31:0] walk_left;
        logic signed [31:0] walk_turn;
        logic signed [31:0] visual_turn;
        logic               visual_valid;
    } frame_in_t;

    typedef struct packed {
        logic signed [31:0] fused_forward;
        logic signed [31:0] fused_left;
        logic signed [31:0] fused_turn;
        logic               used_visual;
        logic signed [31:0] slip_level;
        logic signed [15:0] slip_run;
        logic               caught_left;
        logic               caught_right;
    } frame_out_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  wr_data;
    } cfg_write_t;

endpackage

// ===== rtl/core/osd_frame_in_if.sv =====
// Valid/ready channel carrying one odometry frame.
interface osd_frame_in_if
    import osd_pkg::*;
();
    logic      valid;
    logic      ready;
    frame_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/osd_frame_out_if.sv =====
// Valid/ready channel carrying one fused odometry result.
interface osd_frame_out_if
    import osd_pkg::*;
();
    logic       valid;
    logic       ready;
    frame_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/osd_cfg_if.sv =====
// Valid/ready configuration write channel.
interface osd_cfg_if
    import osd_pkg::*;
();
    logic       valid;
    logic       ready;
    cfg_write_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/odometry_slip_detector.sv =====
// Top level of the odometry slip detector: turn fusion, slip average and caught latches.
//
//  Channel    Dir  Beat contents
//  ---------  ---  ------------------------------------------------------------
//  frame_in   in   walk forward/left/turn, visual turn and its valid flag
//  frame_out  out  fused forward/left/turn, used_visual, slip level, run, latches
//  cfg        in   register index and write data
//
// A frame beat lands in an input register; one pass of logic then writes the whole
// update into the result register, and a frame can be accepted every cycle while the
// result is not stalled. The longest path is the 17 x 33 bit weight multiply into the average.
// A stalled result holds the input register, and frame_in.ready falls once both are full.
// Reset clears the valid flags and frame state and loads the register defaults. Configuration beats
// are always accepted; the user must send them only while no frame is in flight, as nothing checks it.
module odometry_slip_detector
    import osd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    osd_frame_in_if.sink           frame_in,
    osd_frame_out_if.source        frame_out,
    osd_cfg_if.sink                cfg
);

    // Configuration registers.
    logic [30:0] slip_threshold_reg;
    logic [14:0] slip_count_limit_reg;
    logic [15:0] caught_hold_time_reg;
    logic [15:0] average_weight_reg;

    // Frame-to-frame state.
    logic [31:0]        prev_walk_forward_reg;
    logic [31:0]        prev_walk_left_reg;
    logic [31:0]        prev_walk_turn_reg;
    logic [31:0]        prev_visual_turn_reg;
    logic               prev_valid_reg;
    logic signed [31:0] slip_avg_reg;
    logic signed [15:0] slip_counter_reg;
    logic [15:0]        hold_counter_reg;
    logic               left_latch_reg;
    logic               right_latch_reg;
    logic [31:0]        turn_accum_reg;

    // Input and result stages.
    logic       in_valid_reg;
    frame_in_t  in_data_reg;
    logic       out_valid_reg;
    frame_out_t out_data_reg;

    logic advance;

    // Update datapath.
    logic [31:0]        walk_step;
    logic [31:0]        vis_step;
    logic               walking;
    logic               both_valid;
    logic signed [31:0] slip_err;
    logic signed [32:0] avg_diff;
    logic signed [49:0] weighted;
    logic signed [49:0] rounded;
    logic signed [33:0] avg_delta;
    logic signed [33:0] avg_sum;
    logic signed [31:0] slip_avg_next;
    logic signed [32:0] avg_ext;
    logic signed [32:0] thr_ext;
    logic               slip_left;
    logic               slip_right;
    logic               use_vis;
    logic [31:0]        turn_accum_next;
    logic signed [15:0] slip_counter_next;
    logic signed [16:0] run_ext;
    logic signed [16:0] lim_ext;
    logic [15:0]        hold_counter_next;
    logic               left_latch_next;
    logic               right_latch_next;
    frame_out_t         result;

    // The result register moves on when it is empty or being taken; the input
    // register moves into it in the same cycle and can then take a new beat.
    assign advance         = in_valid_reg && (!out_valid_reg || frame_out.ready);
    assign frame_in.ready  = !in_valid_reg || advance;
    assign frame_out.valid = out_valid_reg;
    assign frame_out.data  = out_data_reg;
    assign cfg.ready       = 1'b1;

    // Steps since the previous frame, all wrapping modulo 2^32.
    assign walk_step  = in_data_reg.walk_turn - prev_walk_turn_reg;
    assign vis_step   = in_data_reg.visual_turn - prev_visual_turn_reg;
    assign walking    = (walk_step != '0)
                     || (in_data_reg.walk_forward != prev_walk_forward_reg)
                     || (in_data_reg.walk_left != prev_walk_left_reg);
    assign both_valid = prev_valid_reg && in_data_reg.visual_valid;

    // The slip error only counts when vision is trusted on both frames.
    assign slip_err = both_valid ? $signed(vis_step - walk_step) : '0;

    // w*err + (1-w)*avg is rewritten as avg + w*(err - avg), which needs a
    // single multiply. Rounding adds one half and the arithmetic shift floors.
    assign avg_diff  = $signed({slip_err[31], slip_err})
                     - $signed({slip_avg_reg[31], slip_avg_reg});
    assign weighted  = $signed({1'b0, average_weight_reg}) * avg_diff;
    assign rounded   = weighted + AVG_ROUND;
    assign avg_delta = rounded[49:AVG_SHIFT];
    assign avg_sum   = $signed({{2{slip_avg_reg[31]}}, slip_avg_reg}) + avg_delta;
    // The weighted average stays between its two inputs, so 32 bits hold it.
    assign slip_avg_next = avg_sum[31:0];

    // Slipping left when the average is above the threshold, right when below
    // its negative.
    assign avg_ext    = $signed({slip_avg_next[31], slip_avg_next});
    assign thr_ext    = $signed({2'b00, slip_threshold_reg});
    assign slip_left  = avg_ext > thr_ext;
    assign slip_right = avg_ext < -thr_ext;

    // Vision drives the turn when both frames are valid and the robot is
    // either walking or slipping hard.
    assign use_vis         = both_valid && (walking || slip_left || slip_right);
    assign turn_accum_next = turn_accum_reg + (use_vis ? vis_step : walk_step);

    // Signed slip run, saturating at the 16-bit limits and cleared when neither side slips.
    always_comb
    begin
        slip_counter_next = '0;
        if (slip_left)
        begin
            slip_counter_next = (slip_counter_reg == RUN_MAX) ? slip_counter_reg
                                                             : slip_counter_reg + 16'sd1;
        end
        else if (slip_right)
        begin
            slip_counter_next = (slip_counter_reg == RUN_MIN) ? slip_counter_reg
                                                             : slip_counter_reg - 16'sd1;
        end
    end

    assign run_ext = $signed({slip_counter_next[15], slip_counter_next});
    assign lim_ext = $signed({2'b00, slip_count_limit_reg});

    // Caught latches: a long slip run sets one side and restarts the hold
    // timer; once the timer passes the hold time both latches clear.
    always_comb
    begin
        hold_counter_next = hold_counter_reg;
        left_latch_next   = left_latch_reg;
        right_latch_next  = right_latch_reg;
        if (run_ext > lim_ext)
        begin
            hold_counter_next = 16'd1;
            left_latch_next   = 1'b1;
            right_latch_next  = 1'b0;
        end
        else if (run_ext < -lim_ext)
        begin
            hold_counter_next = 16'd1;
            left_latch_next   = 1'b0;
            right_latch_next  = 1'b1;
        end
        else if (hold_counter_reg > caught_hold_time_reg)
        begin
            hold_counter_next = '0;
            left_latch_next   = 1'b0;
            right_latch_next  = 1'b0;
        end
        else if (hold_counter_reg != '0 && hold_counter_reg != HOLD_MAX)
        begin
            hold_counter_next = hold_counter_reg + 16'd1;
        end
    end

    always_comb
    begin
        result.fused_forward = in_data_reg.walk_forward;
        result.fused_left    = in_data_reg.walk_left;
        result.fused_turn    = $signed(turn_accum_next);
        result.used_visual   = use_vis;
        result.slip_level    = slip_avg_next;
        result.slip_run      = slip_counter_next;
        result.caught_left   = left_latch_next;
        result.caught_right  = right_latch_next;
    end

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slip_threshold_reg   <= SLIP_THRESHOLD_RST;
            slip_count_limit_reg <= SLIP_COUNT_LIMIT_RST;
            caught_hold_time_reg <= CAUGHT_HOLD_TIME_RST;
            average_weight_reg   <= AVERAGE_WEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.reg_index)
                CFG_SLIP_THRESHOLD:   slip_threshold_reg   <= cfg.data.wr_data[30:0];
                CFG_SLIP_COUNT_LIMIT: slip_count_limit_reg <= cfg.data.wr_data[14:0];
                CFG_CAUGHT_HOLD_TIME: caught_hold_time_reg <= cfg.data.wr_data[15:0];
                CFG_AVERAGE_WEIGHT:   average_weight_reg   <= cfg.data.wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame_in.ready)
        begin
            in_valid_reg <= frame_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            in_data_reg <= frame_in.data;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // Frame state commits when the frame's result is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_walk_forward_reg <= '0;
            prev_walk_left_reg    <= '0;
            prev_walk_turn_reg    <= '0;
            prev_visual_turn_reg  <= '0;
            prev_valid_reg        <= 1'b0;
            slip_avg_reg          <= '0;
            slip_counter_reg      <= '0;
            hold_counter_reg      <= '0;
            left_latch_reg        <= 1'b0;
            right_latch_reg       <= 1'b0;
            turn_accum_reg        <= '0;
        end
        else if (advance)
        begin
            prev_walk_forward_reg <= in_data_reg.walk_forward;
            prev_walk_left_reg    <= in_data_reg.walk_left;
            prev_walk_turn_reg    <= in_data_reg.walk_turn;
            prev_visual_turn_reg  <= in_data_reg.visual_turn;
            prev_valid_reg        <= in_data_reg.visual_valid;
            slip_avg_reg          <= slip_avg_next;
            slip_counter_reg      <= slip_counter_next;
            hold_counter_reg      <= hold_counter_next;
            left_latch_reg        <= left_latch_next;
            right_latch_reg       <= right_latch_next;
            turn_accum_reg        <= turn_accum_next;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the odometry slip detector: directed, latch and random frames.
`timescale 1ns / 1ps

module testbench;
    import osd_pkg::*;

    // Clock period is 4 ns. Reset is held low at the start of the run.
    localparam int RESET_CYCLES  = 7;
    // Quiet cycles at the end will show any stray beat.
    localparam int SETTLE_CYCLES = 8;
    // The slowest correct run is about 800 frames, each waiting for a random gap and stall
    // plus the pass through the block. This limit lies well above that.
    localparam int unsigned CYCLE_LIMIT = 100_000;
    // Only the first mismatches are printed. All of them are counted.
    localparam int MAX_REPORTS   = 40;

    // These indexes lie outside the register map, so the block must ignore writes to them.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW  = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

    // The average weight is Q0.16. One is 65536 and one half is 32768.
    localparam longint WEIGHT_ONE = 65536;
    localparam longint ROUND_HALF = 32768;

    // Step of visual turn per frame used to drive a steady slip one way or the other.
    localparam logic [31:0] STEP_SLIP_LEFT  = 32'd1000;
    localparam logic [31:0] STEP_SLIP_RIGHT = -32'sd1000;
    localparam logic [31:0] STEP_HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] STEP_NONE       = 32'd0;

    logic clk = 1'b0;
    logic rst_n;

    osd_frame_in_if  frame_in_bus ();
    osd_frame_out_if frame_out_bus ();
    osd_cfg_if       cfg_bus ();

    odometry_slip_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_in  (frame_in_bus),
        .frame_out (frame_out_bus),
        .cfg       (cfg_bus)
    );

    always #2 clk = ~clk;

    // The local copy of the register file follows every accepted write beat.
    logic [30:0] cfg_threshold;
    logic [14:0] cfg_run_limit;
    logic [15:0] cfg_hold;
    logic [15:0] cfg_weight;

    // This is the local copy of the detector state. It is updated once for each frame sent.
    logic [31:0]        last_fwd;
    logic [31:0]        last_left;
    logic [31:0]        last_wturn;
    logic [31:0]        last_vturn;
    logic               last_valid;
    logic signed [31:0] slip_avg;
    logic signed [15:0] run_count;
    logic [15:0]        hold_count;
    logic               latch_left;
    logic               latch_right;
    logic [31:0]        turn_total;

    // These fused results are still to be delivered, oldest first.
    frame_out_t fused_frames_due[$];

    // These cumulative odometry values carry the random walk from one frame to the next.
    logic [31:0] cum_fwd   = '0;
    logic [31:0] cum_left  = '0;
    logic [31:0] cum_wturn = '0;
    logic [31:0] cum_vturn = '0;
    int          slip_bias    = 0;
    int          episode_left = 0;

    // While this is set, neither side inserts gaps or stalls.
    bit          steady_flow = 1'b0;
    int unsigned frames_sent = 0;
    int unsigned writes_done = 0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // One frame through the detector. It returns the fused beat that the block
    // must produce and advances the local state exactly as the block does.
    function automatic frame_out_t fuse_frame(input frame_in_t f);
        logic [31:0]        walk_step;
        logic [31:0]        vis_step;
        logic signed [31:0] step_gap;
        logic               walking;
        logic               both_valid;
        logic               take_vis;
        longint             err;
        longint             avg;
        longint             w;
        longint             acc;
        longint             level;
        longint             mag;
        longint             thr;
        longint             lim;
        longint             run;
        frame_out_t         r;

        walk_step  = f.walk_turn - last_wturn;
        vis_step   = f.visual_turn - last_vturn;
        walking    = (walk_step != 0) || (f.walk_forward != last_fwd) ||
                     (f.walk_left != last_left);
        both_valid = last_valid && f.visual_valid;

        // The slip error counts only when this frame and the last are both
        // visually valid. It then enters the rounded exponential average.
        step_gap = vis_step - walk_step;
        if (both_valid)
            err = longint'(step_gap);
        else
            err = 0;
        avg   = longint'(slip_avg);
        w     = longint'(cfg_weight);
        acc   = w * err + (WEIGHT_ONE - w) * avg + ROUND_HALF;
        level = acc >>> AVG_SHIFT;
        slip_avg = level[31:0];

        // The turn comes from vision when the robot walks or the slip is large.
        thr      = longint'(cfg_threshold);
        mag      = (level < 0) ? -level : level;
        take_vis = both_valid && (walking || (mag > thr));
        turn_total = turn_total + (take_vis ? vis_step : walk_step);

        // The signed run of slipping frames saturates at both ends of 16 bits and clears without slip.
        run = longint'(run_count);
        if (level > thr) begin
            if (run < RUN_MAX)
                run++;
        end
        else if (level < -thr) begin
            if (run > RUN_MIN)
                run--;
        end
        else begin
            run = 0;
        end
        run_count = run[15:0];

        // Latches are set past the run limit and cleared after the hold time.
        // The hold counter sticks at its maximum.
        lim = longint'(cfg_run_limit);
        if (run > lim) begin
            hold_count  = 16'd1;
            latch_left  = 1'b1;
            latch_right = 1'b0;
        end
        else if (run < -lim) begin
            hold_count  = 16'd1;
            latch_right = 1'b1;
            latch_left  = 1'b0;
        end
        else if (hold_count > cfg_hold) begin
            hold_count  = 16'd0;
            latch_left  = 1'b0;
            latch_right = 1'b0;
        end
        else if (hold_count != 0 && hold_count < HOLD_MAX) begin
            hold_count++;
        end

        last_fwd   = f.walk_forward;
        last_left  = f.walk_left;
        last_wturn = f.walk_turn;
        last_vturn = f.visual_turn;
        last_valid = f.visual_valid;

        r.fused_forward = f.walk_forward;
        r.fused_left    = f.walk_left;
        r.fused_turn    = turn_total;
        r.used_visual   = take_vis;
        r.slip_level    = slip_avg;
        r.slip_run      = run_count;
        r.caught_left   = latch_left;
        r.caught_right  = latch_right;
        return r;
    endfunction

    function automatic frame_in_t make_frame(input logic [31:0] fwd, input logic [31:0] lft,
                                             input logic [31:0] wturn, input logic [31:0] vturn,
                                             input logic valid);
        frame_in_t f;
        f.walk_forward = fwd;
        f.walk_left    = lft;
        f.walk_turn    = wturn;
        f.visual_turn  = vturn;
        f.visual_valid = valid;
        return f;
    endfunction

    // This task sends one frame beat. It leaves valid high after acceptance, so
    // the next frame can follow in the very next cycle.
    task automatic send_frame(input frame_in_t f);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            frame_in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_in_bus.valid <= 1'b1;
        frame_in_bus.data  <= f;
        fused_frames_due.insert(fused_frames_due.size(), fuse_frame(f));
        frames_sent++;
        do @(posedge clk); while (!frame_in_bus.ready);
    endtask

    // This task lowers the frame valid and waits until every fused beat has arrived.
    // Every frame yields exactly one beat, so nothing is left in flight after that.
    // The loop waits on a clock edge before it checks, so the caller's next drive lands in a later step.
    task automatic wait_idle();
        frame_in_bus.valid <= 1'b0;
        do @(posedge clk); while (fused_frames_due.size() != 0);
    endtask

    // This task sends one register write beat and leaves cfg valid high.
    // The caller lowers valid once after a batch of writes.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_write_t w;
        w.reg_index = idx;
        w.wr_data   = value;
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= w;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            CFG_SLIP_THRESHOLD:   cfg_threshold = value[30:0];
            CFG_SLIP_COUNT_LIMIT: cfg_run_limit = value[14:0];
            CFG_CAUGHT_HOLD_TIME: cfg_hold      = value[15:0];
            CFG_AVERAGE_WEIGHT:   cfg_weight    = value[15:0];
            default: ;
        endcase
        writes_done++;
    endtask

    // This task loads all four registers. It waits for the block to go idle first.
    task automatic configure(input logic [31:0] thr, input logic [31:0] lim,
                             input logic [31:0] hold, input logic [31:0] weight);
        wait_idle();
        write_register(CFG_SLIP_THRESHOLD, thr);
        write_register(CFG_SLIP_COUNT_LIMIT, lim);
        write_register(CFG_CAUGHT_HOLD_TIME, hold);
        write_register(CFG_AVERAGE_WEIGHT, weight);
        cfg_bus.valid <= 1'b0;
    endtask

    // This task holds the walk odometry still and moves the visual turn by a
    // fixed step on each valid frame. A nonzero step is a steady slip.
    task automatic stream_constant_slip(input int count, input logic [31:0] vstep);
        repeat (count) begin
            cum_vturn = cum_vturn + vstep;
            send_frame(make_frame(cum_fwd, cum_left, cum_wturn, cum_vturn, 1'b1));
        end
    endtask

    // Most frames are a plausible walk: small steps with episodes of steady slip
    // bias and some invalid vision. A few are arbitrary values.
    task automatic send_random_frame();
        frame_in_t f;
        int        fwd_step;
        int        left_step;
        int        turn_step;
        int        noise;
        if ($urandom_range(0, 99) < 8) begin
            cum_fwd   = $urandom();
            cum_left  = $urandom();
            cum_wturn = $urandom();
            cum_vturn = $urandom();
            f = make_frame(cum_fwd, cum_left, cum_wturn, cum_vturn, 1'($urandom_range(0, 1)));
        end
        else begin
            if (episode_left == 0) begin
                episode_left = $urandom_range(3, 40);
                case ($urandom_range(0, 4))
                    0:       slip_bias = 0;
                    1:       slip_bias = $urandom_range(8000, 60000);
                    2:       slip_bias = -int'($urandom_range(8000, 60000));
                    3:       slip_bias = int'($urandom_range(0, 4000)) - 2000;
                    default: slip_bias = $urandom();
                endcase
            end
            episode_left--;
            if ($urandom_range(0, 3) == 0) begin
                // The robot stands still, so no walk step is made.
                fwd_step  = 0;
                left_step = 0;
                turn_step = 0;
            end
            else begin
                fwd_step  = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 800)) - 400;
                left_step = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 800)) - 400;
                turn_step = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 8000)) - 4000;
            end
            noise     = int'($urandom_range(0, 1000)) - 500;
            cum_fwd   = cum_fwd + fwd_step;
            cum_left  = cum_left + left_step;
            cum_wturn = cum_wturn + turn_step;
            cum_vturn = cum_vturn + turn_step + slip_bias + noise;
            f = make_frame(cum_fwd, cum_left, cum_wturn, cum_vturn, $urandom_range(0, 9) != 0);
        end
        send_frame(f);
    endtask

    // Each field is taken to its largest and smallest values, and to all ones
    // and alternating bit patterns, under the reset configuration.
    task automatic test_field_extremes();
        send_frame(make_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        send_frame(make_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        send_frame(make_frame(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
        send_frame(make_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_frame(make_frame(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
    endtask

    // The robot counts as walking if any one of the three walk steps is nonzero.
    // Each step is moved alone, and then none of them moves.
    task automatic test_walking_detection();
        send_frame(make_frame(32'd100, 32'd100, 32'd100, 32'd100, 1'b1));
        send_frame(make_frame(32'd150, 32'd100, 32'd100, 32'd900, 1'b1));
        send_frame(make_frame(32'd150, 32'd60, 32'd100, 32'd1700, 1'b1));
        send_frame(make_frame(32'd150, 32'd60, 32'd400, 32'd2500, 1'b1));
        send_frame(make_frame(32'd150, 32'd60, 32'd400, 32'd3300, 1'b1));
        send_frame(make_frame(32'd150, 32'd60, 32'd400, 32'd3300, 1'b1));
    endtask

    // An invalid visual frame still replaces the stored visual turn, so the
    // next valid pair measures from it.
    task automatic test_invalid_visual();
        send_frame(make_frame(32'd10, 32'd0, 32'd0, 32'd50000, 1'b0));
        send_frame(make_frame(32'd20, 32'd0, 32'd0, 32'd90000, 1'b1));
        send_frame(make_frame(32'd30, 32'd0, 32'd0, 32'd20000, 1'b0));
        send_frame(make_frame(32'd30, 32'd0, 32'd0, 32'd70000, 1'b0));
        send_frame(make_frame(32'd30, 32'd0, 32'd0, 32'd99000, 1'b1));
        send_frame(make_frame(32'd30, 32'd0, 32'd0, 32'd140000, 1'b1));
    endtask

    // A half turn of slip at full weight drives the average to its most
    // negative value, which only just exceeds the largest threshold. Zero
    // weight then freezes the average.
    task automatic test_average_extremes();
        configure(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd65535);
        stream_constant_slip(5, STEP_HALF_TURN);
        configure(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
        stream_constant_slip(2, STEP_SLIP_LEFT);
    endtask

    // Writes to indexes outside the register map must change nothing.
    task automatic test_unknown_register();
        configure(32'(SLIP_THRESHOLD_RST), 32'(SLIP_COUNT_LIMIT_RST),
                  32'(CAUGHT_HOLD_TIME_RST), 32'(AVERAGE_WEIGHT_RST));
        wait_idle();
        write_register(CFG_UNUSED_LOW, $urandom());
        write_register(CFG_UNUSED_HIGH, $urandom());
        cfg_bus.valid <= 1'b0;
        stream_constant_slip(3, 32'd30000);
    endtask

    // Short runs at full rate set and clear the caught latches. With a short
    // hold time a latch clears once the slip stops. With the hold time at its
    // maximum a latch is cleared only when the robot slips the other way.
    task automatic test_caught_latches();
        steady_flow = 1'b1;
        configure(32'd0, 32'd5, 32'd3, 32'd65535);
        stream_constant_slip(12, STEP_SLIP_LEFT);
        stream_constant_slip(10, STEP_NONE);
        stream_constant_slip(12, STEP_SLIP_RIGHT);
        stream_constant_slip(10, STEP_NONE);
        configure(32'd0, 32'd5, 32'd65535, 32'd65535);
        stream_constant_slip(12, STEP_SLIP_LEFT);
        stream_constant_slip(20, STEP_NONE);
        stream_constant_slip(12, STEP_SLIP_RIGHT);
        wait_idle();
        steady_flow = 1'b0;
    endtask

    // Random traffic runs in phases. The first phase uses the reset values and each
    // later phase draws a new register setting, some of them at the extremes. Every
    // fourth phase runs with no gaps or stalls.
    task automatic test_random_phases();
        logic [31:0] thr;
        logic [31:0] lim;
        logic [31:0] hold;
        logic [31:0] weight;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                thr    = 32'(SLIP_THRESHOLD_RST);
                lim    = 32'(SLIP_COUNT_LIMIT_RST);
                hold   = 32'(CAUGHT_HOLD_TIME_RST);
                weight = 32'(AVERAGE_WEIGHT_RST);
            end
            else begin
                case ($urandom_range(0, 5))
                    0:       thr = 32'd0;
                    1:       thr = 32'h7FFF_FFFF;
                    2:       thr = $urandom();
                    default: thr = $urandom_range(0, 30000);
                endcase
                case ($urandom_range(0, 5))
                    0:       lim = 32'd0;
                    1:       lim = 32'd32767;
                    2:       lim = $urandom();
                    default: lim = $urandom_range(0, 12);
                endcase
                case ($urandom_range(0, 6))
                    0:       hold = 32'd0;
                    1:       hold = 32'd65535;
                    2:       hold = 32'd65534;
                    3:       hold = $urandom();
                    default: hold = $urandom_range(0, 40);
                endcase
                case ($urandom_range(0, 5))
                    0:       weight = 32'd0;
                    1:       weight = 32'd65535;
                    2:       weight = $urandom();
                    default: weight = $urandom_range(4000, 40000);
                endcase
            end
            configure(thr, lim, hold, weight);
            steady_flow = (phase % 4 == 3);
            repeat (90) send_random_frame();
        end
        wait_idle();
        steady_flow = 1'b0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // This task compares one accepted result beat with the oldest outstanding prediction.
    task automatic check_beat(input frame_out_t got);
        frame_out_t want;
        if (fused_frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t ns: result beat with no frame outstanding, expected none, actual %h",
                         $time, got);
        end
        else begin
            want = fused_frames_due.pop_front();
            check_field("fused_forward", longint'(want.fused_forward),
                        longint'(got.fused_forward));
            check_field("fused_left", longint'(want.fused_left), longint'(got.fused_left));
            check_field("fused_turn", longint'(want.fused_turn), longint'(got.fused_turn));
            check_field("used_visual", longint'(want.used_visual), longint'(got.used_visual));
            check_field("slip_level", longint'(want.slip_level), longint'(got.slip_level));
            check_field("slip_run", longint'(want.slip_run), longint'(got.slip_run));
            check_field("caught_left", longint'(want.caught_left), longint'(got.caught_left));
            check_field("caught_right", longint'(want.caught_right),
                        longint'(got.caught_right));
        end
    endtask

    // The result side draws a stall before each beat, unless steady flow is on.
    // Ready stays high across back-to-back beats and is lowered only at the
    // edge where a beat is taken.
    initial begin : result_sink
        int stall;
        frame_out_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                frame_out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            frame_out_bus.ready <= 1'b1;
            do @(posedge clk); while (!frame_out_bus.valid);
            check_beat(frame_out_bus.data);
        end
    end

    // This is the watchdog. A hung handshake or a missing result ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, fused_frames_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        // Every input gets a known value at time zero. Reset is applied once here.
        rst_n              <= 1'b0;
        frame_in_bus.valid <= 1'b0;
        frame_in_bus.data  <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.data       <= '0;

        cfg_threshold = SLIP_THRESHOLD_RST;
        cfg_run_limit = SLIP_COUNT_LIMIT_RST;
        cfg_hold      = CAUGHT_HOLD_TIME_RST;
        cfg_weight    = AVERAGE_WEIGHT_RST;
        last_fwd      = '0;
        last_left     = '0;
        last_wturn    = '0;
        last_vturn    = '0;
        last_valid    = 1'b0;
        slip_avg      = '0;
        run_count     = '0;
        hold_count    = '0;
        latch_left    = 1'b0;
        latch_right   = 1'b0;
        turn_total    = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_walking_detection();
        test_invalid_visual();
        test_average_extremes();
        test_unknown_register();
        test_random_phases();
        test_caught_latches();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d frames across %0d register writes, %0d mismatches.",
                 frames_sent, writes_done, mismatches);
        $display("Covered field extremes, walking and vision validity, average limits and latches.");
        if (mismatches == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/osd_pkg.sv
rtl/core/osd_frame_in_if.sv
rtl/core/osd_frame_out_if.sv
rtl/core/osd_cfg_if.sv
rtl/core/odometry_slip_detector.sv
verif/testbench.sv
